>>> hw/rtl/cse_pkg.sv
// Shared types and constants of the contour segment extractor.
// Depends on nothing; every file of the block but cse_chk uses it.
package cse_pkg;

	typedef logic signed [31:0] q16_t;

	localparam int NLANES    = 4;
	localparam int POS_LAT   = 4;
	localparam int DIV_STEPS = 30;
	localparam int LANE_LAT  = DIV_STEPS + 3;
	localparam int PIPE_LAT  = POS_LAT + LANE_LAT + 1;
	localparam int MAX_GRID  = 1024;
	localparam int GRID_MIN  = 2;

	// Serial divider length of the setup pass (43-bit dividend).
	localparam logic [5:0] SETUP_STEPS = 6'd43;

	typedef enum logic [2:0] {
		REG_LEVEL     = 3'd0,
		REG_X_MIN     = 3'd1,
		REG_X_MAX     = 3'd2,
		REG_Y_MIN     = 3'd3,
		REG_Y_MAX     = 3'd4,
		REG_GRID_COLS = 3'd5,
		REG_GRID_ROWS = 3'd6
	} reg_idx_t;

	// Per-axis position constants: span = q0 * dd + r0, recip = floor(2^32 / dd).
	typedef struct packed {
		q16_t               lo;
		logic signed [32:0] q0;
		logic [11:0]        r0;
		logic [30:0]        recip;
		logic [11:0]        dd;
	} axis_t;

	typedef struct packed {
		q16_t  level;
		axis_t ax;
		axis_t ay;
		logic  busy;
	} setup_t;

	// One edge crossing in flight through the restoring divider.
	typedef struct packed {
		logic [31:0] r;
		logic [31:0] d;
		logic [29:0] q;
		q16_t        ax;
		q16_t        ay;
		q16_t        bx;
		q16_t        by;
	} xing_t;

	typedef struct packed {
		q16_t sx;
		q16_t sy;
		q16_t ex;
		q16_t ey;
	} seg_t;

endpackage

>>> hw/rtl/cse_if.sv
// Valid/ready channel interfaces of the contour segment extractor:
// configuration writes, input cells and output segments. Uses cse_pkg.
interface cse_cfg_if;
	logic                 valid;
	logic                 ready;
	logic [2:0]           addr;
	logic [31:0]          data;
	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

interface cse_in_if;
	logic                 valid;
	logic                 ready;
	logic [9:0]           cell_col;
	logic [9:0]           cell_row;
	cse_pkg::q16_t        value_low_left;
	cse_pkg::q16_t        value_low_right;
	cse_pkg::q16_t        value_up_right;
	cse_pkg::q16_t        value_up_left;
	modport source (output valid, cell_col, cell_row, value_low_left, value_low_right,
		value_up_right, value_up_left, input ready);
	modport sink (input valid, cell_col, cell_row, value_low_left, value_low_right,
		value_up_right, value_up_left, output ready);
endinterface

interface cse_out_if;
	logic                 valid;
	logic                 ready;
	cse_pkg::q16_t        start_x;
	cse_pkg::q16_t        start_y;
	cse_pkg::q16_t        end_x;
	cse_pkg::q16_t        end_y;
	logic [1:0]           triangle_index;
	logic                 last_of_cell;
	modport source (output valid, start_x, start_y, end_x, end_y, triangle_index,
		last_of_cell, input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, triangle_index,
		last_of_cell, output ready);
endinterface

>>> hw/rtl/contour_segment_extractor.sv
// Top level of the contour segment extractor: input staging, position units, four
// triangle lanes and the merge register. Uses cse_pkg, cse_if, cse_cfg, cse_pos, cse_lane.
//
// One cell word enters per cycle unless the pipeline stalls or setup runs, and
// leaves as 0 to 4 segment words, in triangle order. The whole pipeline advances
// together; it stalls only while the merge register still holds segments of the
// previous cell, which leave one at a time over the single output channel as
// seg_out.ready takes them. Six coordinate units compute the cell's sample and center
// positions and four lanes, one per triangle, each run two 30-stage restoring
// dividers for the crossing fractions. After reset and after every configuration
// write, a setup pass (four serial 43-step divisions for the axis constants) holds
// cell_in.ready low; configuration words are taken at any time.
module contour_segment_extractor (
	input  logic      clk,
	input  logic      arst_n,
	cse_cfg_if.sink   cfg,
	cse_in_if.sink    cell_in,
	cse_out_if.source seg_out
);
	localparam int NL = cse_pkg::NLANES;
	localparam int PL = cse_pkg::POS_LAT;
	localparam int LL = cse_pkg::PIPE_LAT;

	typedef struct packed {
		cse_pkg::q16_t ll;
		cse_pkg::q16_t lr;
		cse_pkg::q16_t ur;
		cse_pkg::q16_t ul;
		cse_pkg::q16_t c;
	} zset_t;

	cse_pkg::setup_t setup;
	logic            adv, hold, acc;
	logic            vld_s[0:LL-1];
	logic [9:0]      col_s1, row_s1;
	zset_t           zd_s[0:PL];
	logic signed [33:0] zsum;
	logic [11:0]     kx[3], ky[3];
	cse_pkg::q16_t   px[3], py[3];
	cse_pkg::q16_t   cz[NL], cx[NL], cy[NL];
	logic [NL-1:0]   seg_v;
	cse_pkg::seg_t   lane_res[NL];
	logic [NL-1:0]   mask_q, sel;
	cse_pkg::seg_t   segs_q[NL];
	logic [1:0]      idx;
	logic            last;

	cse_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.setup  (setup)
	);

	// Advance everything unless the merge register keeps segments this cycle.
	assign adv           = ~hold;
	assign cell_in.ready = adv & ~setup.busy;
	assign acc           = cell_in.valid & cell_in.ready;

	// Center value: floor of the corner mean, an arithmetic shift of the sum.
	assign zsum = {{2{cell_in.value_low_left[31]}}, cell_in.value_low_left}
	            + {{2{cell_in.value_low_right[31]}}, cell_in.value_low_right}
	            + {{2{cell_in.value_up_right[31]}}, cell_in.value_up_right}
	            + {{2{cell_in.value_up_left[31]}}, cell_in.value_up_left};

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1     <= cell_in.cell_col;
			row_s1     <= cell_in.cell_row;
			zd_s[0].ll <= cell_in.value_low_left;
			zd_s[0].lr <= cell_in.value_low_right;
			zd_s[0].ur <= cell_in.value_up_right;
			zd_s[0].ul <= cell_in.value_up_left;
			zd_s[0].c  <= zsum[33:2];
			// hold the samples beside the position units
			for (int m = 1; m <= PL; m++)
				zd_s[m] <= zd_s[m-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < LL; m++)
				vld_s[m] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= acc;
			for (int m = 1; m < LL; m++)
				vld_s[m] <= vld_s[m-1];
		end
	end

	// Half-step indices: left/bottom 2i+1, right/top 2i+3, center 2i+2.
	always_comb begin
		kx[0] = {1'b0, col_s1, 1'b1};
		kx[1] = {1'b0, col_s1, 1'b1} + 12'd2;
		kx[2] = {1'b0, col_s1, 1'b0} + 12'd2;
		ky[0] = {1'b0, row_s1, 1'b1};
		ky[1] = {1'b0, row_s1, 1'b1} + 12'd2;
		ky[2] = {1'b0, row_s1, 1'b0} + 12'd2;
	end

	for (genvar g = 0; g < 3; g++) begin : g_pos
		cse_pos u_pos_x (
			.clk  (clk),
			.adv  (adv),
			.axis (setup.ax),
			.k    (kx[g]),
			.pos  (px[g])
		);
		cse_pos u_pos_y (
			.clk  (clk),
			.adv  (adv),
			.axis (setup.ay),
			.k    (ky[g]),
			.pos  (py[g])
		);
	end

	// Corners counterclockwise from lower left.
	always_comb begin
		cz[0] = zd_s[PL].ll;  cx[0] = px[0];  cy[0] = py[0];
		cz[1] = zd_s[PL].lr;  cx[1] = px[1];  cy[1] = py[0];
		cz[2] = zd_s[PL].ur;  cx[2] = px[1];  cy[2] = py[1];
		cz[3] = zd_s[PL].ul;  cx[3] = px[0];  cy[3] = py[1];
	end

	for (genvar t = 0; t < NL; t++) begin : g_lane
		localparam int TN = (t + 1) % NL;
		cse_lane u_lane (
			.clk   (clk),
			.adv   (adv),
			.level (setup.level),
			.z0    (cz[t]),
			.z1    (cz[TN]),
			.zc    (zd_s[PL].c),
			.x0    (cx[t]),
			.y0    (cy[t]),
			.x1    (cx[TN]),
			.y1    (cy[TN]),
			.xc    (px[2]),
			.yc    (py[2]),
			.seg   (seg_v[t]),
			.res   (lane_res[t])
		);
	end

	// Merge: drain the cell's segments lowest triangle first.
	always_comb begin
		sel = mask_q & (~mask_q + NL'(1));
		priority if (mask_q[0]) idx = 2'd0;
		else if (mask_q[1])     idx = 2'd1;
		else if (mask_q[2])     idx = 2'd2;
		else                    idx = 2'd3;
		last = (mask_q & ~sel) == '0;
		hold = (|mask_q) & ~(seg_out.ready & last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mask_q <= '0;
		else if (adv)
			mask_q <= vld_s[LL-1] ? seg_v : '0;
		else if (seg_out.ready)
			mask_q <= mask_q & ~sel;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int t = 0; t < NL; t++)
				segs_q[t] <= lane_res[t];
		end
	end

	assign seg_out.valid          = |mask_q;
	assign seg_out.start_x        = segs_q[idx].sx;
	assign seg_out.start_y        = segs_q[idx].sy;
	assign seg_out.end_x          = segs_q[idx].ex;
	assign seg_out.end_y          = segs_q[idx].ey;
	assign seg_out.triangle_index = idx;
	assign seg_out.last_of_cell   = last;

endmodule

>>> hw/rtl/cse_cfg.sv
// Configuration registers and the setup pass that derives per-axis position constants
// with one shared bit-serial divider. Uses cse_pkg and cse_cfg_if.
module cse_cfg (
	input  logic             clk,
	input  logic             arst_n,
	cse_cfg_if.sink          cfg,
	output cse_pkg::setup_t  setup
);
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	localparam logic [1:0] OP_X_RANGE = 2'd0;
	localparam logic [1:0] OP_X_RECIP = 2'd1;
	localparam logic [1:0] OP_Y_RANGE = 2'd2;
	localparam logic [1:0] OP_Y_RECIP = 2'd3;

	state_t              state_q;
	logic [1:0]          op_q;
	logic [5:0]          cnt_q;
	cse_pkg::q16_t       level_q, x_min_q, x_max_q, y_min_q, y_max_q;
	logic [10:0]         cols_q, rows_q;
	logic [42:0]         dvd_q;
	logic [11:0]         rem_q;
	logic signed [32:0]  q0x_q, q0y_q;
	logic [11:0]         r0x_q, r0y_q;
	logic [30:0]         recx_q, recy_q;

	logic                use_y, is_recip;
	logic [11:0]         ddx, ddy, dd;
	logic signed [32:0]  span;
	logic [42:0]         load_val, dvd_n, q0_wide;
	logic [12:0]         rem_sh;
	logic                ge;
	logic [11:0]         rem_n;

	function automatic logic [10:0] clamp_n(input logic [10:0] n);
		logic [10:0] r;
		r = n;
		if (n < 11'(cse_pkg::GRID_MIN))
			r = 11'(cse_pkg::GRID_MIN);
		else if (n > 11'(cse_pkg::MAX_GRID))
			r = 11'(cse_pkg::MAX_GRID);
		return r;
	endfunction

	assign cfg.ready = 1'b1;

	always_comb begin
		ddx      = {clamp_n(cols_q), 1'b0};
		ddy      = {clamp_n(rows_q), 1'b0};
		use_y    = (op_q == OP_Y_RANGE) || (op_q == OP_Y_RECIP);
		is_recip = (op_q == OP_X_RECIP) || (op_q == OP_Y_RECIP);
		dd       = use_y ? ddy : ddx;
		span     = use_y ? ({y_max_q[31], y_max_q} - {y_min_q[31], y_min_q})
		                 : ({x_max_q[31], x_max_q} - {x_min_q[31], x_min_q});
		// bias by dd * 2^31 so the division runs on a positive dividend
		load_val = is_recip ? (43'd1 << 32)
		                    : ({{10{span[32]}}, span} + ({31'd0, dd} << 31));
		rem_sh   = {rem_q, dvd_q[42]};
		ge       = rem_sh >= {1'b0, dd};
		rem_n    = ge ? 12'(rem_sh - {1'b0, dd}) : rem_sh[11:0];
		dvd_n    = {dvd_q[41:0], ge};
		q0_wide  = dvd_n - (43'd1 << 31);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			op_q    <= OP_X_RANGE;
			cnt_q   <= '0;
			level_q <= '0;
			x_min_q <= '0;
			x_max_q <= 32'sd65536;
			y_min_q <= '0;
			y_max_q <= 32'sd65536;
			cols_q  <= 11'(cse_pkg::GRID_MIN);
			rows_q  <= 11'(cse_pkg::GRID_MIN);
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				cse_pkg::REG_LEVEL:     level_q <= cfg.data;
				cse_pkg::REG_X_MIN:     x_min_q <= cfg.data;
				cse_pkg::REG_X_MAX:     x_max_q <= cfg.data;
				cse_pkg::REG_Y_MIN:     y_min_q <= cfg.data;
				cse_pkg::REG_Y_MAX:     y_max_q <= cfg.data;
				cse_pkg::REG_GRID_COLS: cols_q  <= cfg.data[10:0];
				cse_pkg::REG_GRID_ROWS: rows_q  <= cfg.data[10:0];
				default: ;
			endcase
			// restart the setup pass on every write
			state_q <= ST_RUN;
			op_q    <= OP_X_RANGE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: ;
				ST_RUN: begin
					if (cnt_q == cse_pkg::SETUP_STEPS) begin
						cnt_q <= '0;
						op_q  <= op_q + 2'd1;
						if (op_q == OP_Y_RECIP)
							state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RUN) begin
			if (cnt_q == '0) begin
				dvd_q <= load_val;
				rem_q <= '0;
			end else begin
				dvd_q <= dvd_n;
				rem_q <= rem_n;
				if (cnt_q == cse_pkg::SETUP_STEPS) begin
					unique case (op_q)
						OP_X_RANGE: begin
							q0x_q <= q0_wide[32:0];
							r0x_q <= rem_n;
						end
						OP_X_RECIP: recx_q <= dvd_n[30:0];
						OP_Y_RANGE: begin
							q0y_q <= q0_wide[32:0];
							r0y_q <= rem_n;
						end
						OP_Y_RECIP: recy_q <= dvd_n[30:0];
						default: ;
					endcase
				end
			end
		end
	end

	always_comb begin
		setup.level    = level_q;
		setup.ax.lo    = x_min_q;
		setup.ax.q0    = q0x_q;
		setup.ax.r0    = r0x_q;
		setup.ax.recip = recx_q;
		setup.ax.dd    = ddx;
		setup.ay.lo    = y_min_q;
		setup.ay.q0    = q0y_q;
		setup.ay.r0    = r0y_q;
		setup.ay.recip = recy_q;
		setup.ay.dd    = ddy;
		setup.busy     = (state_q == ST_RUN);
	end

endmodule

>>> hw/rtl/cse_pos.sv
// Four-stage pipeline for one sample coordinate: lo + floor(k * span / dd), saturated.
// Uses cse_pkg.
module cse_pos (
	input  logic            clk,
	input  logic            adv,
	input  cse_pkg::axis_t  axis,
	input  logic [11:0]     k,
	output cse_pkg::q16_t   pos
);
	logic signed [45:0] mkq_s1, mkq_s2, mkq_s3;
	logic [23:0]        kr_s1, kr_s2, kr_s3;
	logic [54:0]        prod_s2;
	logic [22:0]        qe_s3;
	logic [23:0]        qd_s3;
	cse_pkg::q16_t      pos_s4;

	logic signed [45:0] k46, q46;
	logic [34:0]        qd_full;
	logic [23:0]        rem, qf;
	logic signed [47:0] sum;

	always_comb begin
		k46     = {34'd0, k};
		q46     = {{13{axis.q0[32]}}, axis.q0};
		qd_full = {12'd0, prod_s2[54:32]} * {23'd0, axis.dd};
		rem     = kr_s3 - qd_s3;
		// reciprocal estimate is at most one low
		qf      = {1'b0, qe_s3} + 24'(rem >= {12'd0, axis.dd});
		sum     = {{16{axis.lo[31]}}, axis.lo} + {{2{mkq_s3[45]}}, mkq_s3} + {24'd0, qf};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mkq_s1  <= k46 * q46;
			kr_s1   <= {12'd0, k} * {12'd0, axis.r0};
			mkq_s2  <= mkq_s1;
			kr_s2   <= kr_s1;
			prod_s2 <= {31'd0, kr_s1} * {24'd0, axis.recip};
			mkq_s3  <= mkq_s2;
			kr_s3   <= kr_s2;
			qe_s3   <= prod_s2[54:32];
			qd_s3   <= qd_full[23:0];
			if (sum > 48'sh0000_7FFF_FFFF)
				pos_s4 <= 32'sh7FFF_FFFF;
			else if (sum < -48'sh0000_8000_0000)
				pos_s4 <= 32'sh8000_0000;
			else
				pos_s4 <= sum[31:0];
		end
	end

	assign pos = pos_s4;

endmodule

>>> hw/rtl/cse_lane.sv
// One triangle lane: classify, pick start and end crossings, divide bit-serially
// over a pipeline, then interpolate. Uses cse_pkg.
module cse_lane (
	input  logic           clk,
	input  logic           adv,
	input  cse_pkg::q16_t  level,
	input  cse_pkg::q16_t  z0,
	input  cse_pkg::q16_t  z1,
	input  cse_pkg::q16_t  zc,
	input  cse_pkg::q16_t  x0,
	input  cse_pkg::q16_t  y0,
	input  cse_pkg::q16_t  x1,
	input  cse_pkg::q16_t  y1,
	input  cse_pkg::q16_t  xc,
	input  cse_pkg::q16_t  yc,
	output logic           seg,
	output cse_pkg::seg_t  res
);
	localparam int NS = cse_pkg::DIV_STEPS;

	cse_pkg::xing_t     xs_s[0:NS];
	cse_pkg::xing_t     xe_s[0:NS];
	logic               seg_s[0:NS+2];
	logic signed [63:0] msx_s, msy_s, mex_s, mey_s;
	cse_pkg::q16_t      asx_s, asy_s, aex_s, aey_s;
	cse_pkg::seg_t      res_s;

	cse_pkg::q16_t  vz[3], vx[3], vy[3];
	logic [2:0]     ab, bl, cr;
	logic [1:0]     es, ee, opp;
	logic           on_opp;
	cse_pkg::xing_t ex[3], vtx[3], xs_n, xe_n;
	logic signed [63:0] tsx, tsy, tex, tey;

	function automatic cse_pkg::xing_t mk_xing(input cse_pkg::q16_t za, zb, ax, ay,
		bx, by, lv);
		cse_pkg::xing_t     x;
		logic signed [32:0] n, d;
		n = {lv[31], lv} - {za[31], za};
		d = {zb[31], zb} - {za[31], za};
		if (d[32]) begin
			n = -n;
			d = -d;
		end
		x.r  = n[31:0];
		x.d  = d[31:0];
		x.q  = '0;
		x.ax = ax;
		x.ay = ay;
		x.bx = bx;
		x.by = by;
		return x;
	endfunction

	function automatic cse_pkg::xing_t div_step(input cse_pkg::xing_t xi);
		cse_pkg::xing_t x;
		logic [32:0]    t;
		x = xi;
		t = {xi.r, 1'b0};
		if (t >= {1'b0, xi.d}) begin
			x.r = 32'(t - {1'b0, xi.d});
			x.q = {xi.q[28:0], 1'b1};
		end else begin
			x.r = t[31:0];
			x.q = {xi.q[28:0], 1'b0};
		end
		return x;
	endfunction

	function automatic logic signed [63:0] mul_frac(input logic [29:0] q,
		input cse_pkg::q16_t a, b);
		logic signed [32:0] diff;
		diff = {b[31], b} - {a[31], a};
		return $signed({34'd0, q}) * $signed({{31{diff[32]}}, diff});
	endfunction

	always_comb begin
		vz[0] = z0;  vz[1] = z1;  vz[2] = zc;
		vx[0] = x0;  vx[1] = x1;  vx[2] = xc;
		vy[0] = y0;  vy[1] = y1;  vy[2] = yc;
		for (int e = 0; e < 3; e++) begin
			ab[e] = vz[e] > level;
			bl[e] = vz[e] < level;
		end
		cr[0] = (ab[0] & bl[1]) | (bl[0] & ab[1]);
		cr[1] = (ab[1] & bl[2]) | (bl[1] & ab[2]);
		cr[2] = (ab[2] & bl[0]) | (bl[2] & ab[0]);
		ex[0] = mk_xing(vz[0], vz[1], vx[0], vy[0], vx[1], vy[1], level);
		ex[1] = mk_xing(vz[1], vz[2], vx[1], vy[1], vx[2], vy[2], level);
		ex[2] = mk_xing(vz[2], vz[0], vx[2], vy[2], vx[0], vy[0], level);
		// a vertex on the level rides as a zero-length crossing
		for (int e = 0; e < 3; e++) begin
			vtx[e]    = ex[e];
			vtx[e].r  = '0;
			vtx[e].d  = 32'd1;
			vtx[e].bx = vtx[e].ax;
			vtx[e].by = vtx[e].ay;
		end
		priority if (cr[0]) begin
			es = 2'd0; opp = 2'd2; ee = cr[1] ? 2'd1 : 2'd2;
		end else if (cr[1]) begin
			es = 2'd1; opp = 2'd0; ee = 2'd2;
		end else begin
			es = 2'd2; opp = 2'd1; ee = 2'd2;
		end
		unique case (opp)
			2'd0:    on_opp = ~ab[0] & ~bl[0];
			2'd1:    on_opp = ~ab[1] & ~bl[1];
			default: on_opp = ~ab[2] & ~bl[2];
		endcase
		unique case (es)
			2'd0:    xs_n = ex[0];
			2'd1:    xs_n = ex[1];
			default: xs_n = ex[2];
		endcase
		if (on_opp) begin
			unique case (opp)
				2'd0:    xe_n = vtx[0];
				2'd1:    xe_n = vtx[1];
				default: xe_n = vtx[2];
			endcase
		end else begin
			unique case (ee)
				2'd1:    xe_n = ex[1];
				default: xe_n = ex[2];
			endcase
		end
		tsx = msx_s >>> 30;
		tsy = msy_s >>> 30;
		tex = mex_s >>> 30;
		tey = mey_s >>> 30;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xs_s[0]  <= xs_n;
			xe_s[0]  <= xe_n;
			seg_s[0] <= (|ab) & (|bl);
			for (int m = 1; m <= NS; m++) begin
				xs_s[m]  <= div_step(xs_s[m-1]);
				xe_s[m]  <= div_step(xe_s[m-1]);
				seg_s[m] <= seg_s[m-1];
			end
			msx_s       <= mul_frac(xs_s[NS].q, xs_s[NS].ax, xs_s[NS].bx);
			msy_s       <= mul_frac(xs_s[NS].q, xs_s[NS].ay, xs_s[NS].by);
			mex_s       <= mul_frac(xe_s[NS].q, xe_s[NS].ax, xe_s[NS].bx);
			mey_s       <= mul_frac(xe_s[NS].q, xe_s[NS].ay, xe_s[NS].by);
			asx_s       <= xs_s[NS].ax;
			asy_s       <= xs_s[NS].ay;
			aex_s       <= xe_s[NS].ax;
			aey_s       <= xe_s[NS].ay;
			seg_s[NS+1] <= seg_s[NS];
			res_s.sx    <= asx_s + tsx[31:0];
			res_s.sy    <= asy_s + tsy[31:0];
			res_s.ex    <= aex_s + tex[31:0];
			res_s.ey    <= aey_s + tey[31:0];
			seg_s[NS+2] <= seg_s[NS+1];
		end
	end

	assign seg = seg_s[NS+2];
	assign res = res_s;

endmodule

>>> hw/rtl/cse_chk.sv
// Port-level checker for the contour segment extractor and its bind.
// Depends on the top level's interface ports only.
module cse_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_last,
	input logic [1:0]  out_tri,
	input logic [31:0] out_sx,
	input logic [31:0] out_ey
);
	// a stalled segment word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sx) && $stable(out_ey)
			&& $stable(out_tri))
		else $error("segment word changed while stalled");

	// more segments of the cell follow at once, in rising triangle order
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid && (out_tri > $past(out_tri)))
		else $error("segments of a cell out of order or broken");

	// a configuration write starts the setup pass, which blocks cells
	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !in_ready)
		else $error("cell accepted right after a configuration write");
endmodule

bind contour_segment_extractor cse_chk u_cse_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready),
	.in_ready  (cell_in.ready),
	.out_valid (seg_out.valid),
	.out_ready (seg_out.ready),
	.out_last  (seg_out.last_of_cell),
	.out_tri   (seg_out.triangle_index),
	.out_sx    (seg_out.start_x),
	.out_ey    (seg_out.end_y)
);

>>> sim/tb_contour_segment_extractor.sv
// Testbench of contour_segment_extractor: directed and random cells against a predictor.
// It covers register settings, backpressure and random idling on the cell and segment channels.
// Depends on cse_pkg, the cse_*_if interfaces and the top level of the block.
module tb_contour_segment_extractor;
	timeunit 1ns;
	timeprecision 1ps;

	// One input cell and one segment word as the predictor sees them.
	typedef struct {
		logic [9:0]    col;
		logic [9:0]    row;
		cse_pkg::q16_t z[4];
	} cell_t;

	typedef struct {
		cse_pkg::q16_t sx;
		cse_pkg::q16_t sy;
		cse_pkg::q16_t ex;
		cse_pkg::q16_t ey;
		logic [1:0]    tri_idx;
		logic          last;
	} seg_word_t;

	localparam longint Q30 = 64'sd1073741824;

	logic clk;
	logic arst_n;

	cse_cfg_if cfg_if ();
	cse_in_if  in_if ();
	cse_out_if out_if ();

	contour_segment_extractor i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.cell_in(in_if),
		.seg_out(out_if)
	);

	// Register copy of the predictor, kept in step with accepted writes.
	longint     lvl, xlo, xhi, ylo, yhi;
	logic [10:0] ncols, nrows;

	seg_word_t  pending_segs[$];
	int         mismatches = 0;
	bit         steady = 0;      // no idling on either side while set
	int         hold_off = 0;    // long receiver stall requested by a test

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic longint fdiv(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0)
			q--;
		return q;
	endfunction

	function automatic longint clamp_grid(logic [10:0] n);
		if (n < cse_pkg::GRID_MIN)
			return cse_pkg::GRID_MIN;
		if (n > cse_pkg::MAX_GRID)
			return cse_pkg::MAX_GRID;
		return n;
	endfunction

	// Cell-centered position at half-step k, saturated to 32 bits.
	function automatic longint grid_pos(longint lo, longint hi, longint n, longint k);
		longint v;
		v = lo + fdiv(k * (hi - lo), 2 * n);
		if (v > 64'sd2147483647)
			v = 64'sd2147483647;
		if (v < -64'sd2147483648)
			v = -64'sd2147483648;
		return v;
	endfunction

	function automatic int side_of(longint z);
		if (z == lvl)
			return 0;
		return (z > lvl) ? 1 : -1;
	endfunction

	// Interpolate the level crossing on edge a->b.
	function automatic void edge_point(longint ax, longint ay, longint az, longint bx,
			longint by, longint bz, output longint px, output longint py);
		longint n, d, s;
		n = lvl - az;
		d = bz - az;
		if (d < 0) begin
			n = -n;
			d = -d;
		end
		s = (n * Q30) / d;
		px = ax + fdiv(s * (bx - ax), Q30);
		py = ay + fdiv(s * (by - ay), Q30);
	endfunction

	// Work out the segments of one cell and queue them in triangle order.
	function automatic void trace_cell(cell_t c);
		longint nc, nr, xl, xr, xc, yb, yt, yc, cz;
		longint cx[4], cy[4], vx[3], vy[3], vz[3], px, py, sx, sy, ex, ey;
		int f[3];
		int first_new, a, b, opp;
		bit above, below, have_start, done;
		seg_word_t w;

		nc = clamp_grid(ncols);
		nr = clamp_grid(nrows);
		xl = grid_pos(xlo, xhi, nc, 2 * c.col + 1);
		xr = grid_pos(xlo, xhi, nc, 2 * c.col + 3);
		xc = grid_pos(xlo, xhi, nc, 2 * c.col + 2);
		yb = grid_pos(ylo, yhi, nr, 2 * c.row + 1);
		yt = grid_pos(ylo, yhi, nr, 2 * c.row + 3);
		yc = grid_pos(ylo, yhi, nr, 2 * c.row + 2);
		cx[0] = xl; cy[0] = yb;
		cx[1] = xr; cy[1] = yb;
		cx[2] = xr; cy[2] = yt;
		cx[3] = xl; cy[3] = yt;
		cz = fdiv(longint'(c.z[0]) + c.z[1] + c.z[2] + c.z[3], 4);
		first_new = pending_segs.size();

		for (int t = 0; t < 4; t++) begin
			vx[0] = cx[t];           vy[0] = cy[t];           vz[0] = c.z[t];
			vx[1] = cx[(t + 1) % 4]; vy[1] = cy[(t + 1) % 4]; vz[1] = c.z[(t + 1) % 4];
			vx[2] = xc;              vy[2] = yc;              vz[2] = cz;
			above = 0;
			below = 0;
			for (int e = 0; e < 3; e++) begin
				f[e] = side_of(vz[e]);
				if (f[e] > 0) above = 1;
				if (f[e] < 0) below = 1;
			end
			if (!(above && below))
				continue;
			have_start = 0;
			done = 0;
			sx = 0; sy = 0; ex = 0; ey = 0;
			for (int e = 0; e < 3 && !done; e++) begin
				a = e;
				b = (e + 1) % 3;
				opp = (e + 2) % 3;
				if (f[a] * f[b] >= 0)
					continue;
				edge_point(vx[a], vy[a], vz[a], vx[b], vy[b], vz[b], px, py);
				if (!have_start) begin
					sx = px;
					sy = py;
					have_start = 1;
					// a vertex exactly on the level closes the segment
					if (f[opp] == 0) begin
						ex = vx[opp];
						ey = vy[opp];
						done = 1;
					end
				end else begin
					ex = px;
					ey = py;
					done = 1;
				end
			end
			w.sx = sx[31:0];
			w.sy = sy[31:0];
			w.ex = ex[31:0];
			w.ey = ey[31:0];
			w.tri_idx = t[1:0];
			w.last = 0;
			pending_segs.push_back(w);
		end
		if (pending_segs.size() > first_new)
			pending_segs[pending_segs.size() - 1].last = 1;
	endfunction

	function automatic void model_write(cse_pkg::reg_idx_t idx, logic [31:0] d);
		case (idx)
			cse_pkg::REG_LEVEL:     lvl = $signed(d);
			cse_pkg::REG_X_MIN:     xlo = $signed(d);
			cse_pkg::REG_X_MAX:     xhi = $signed(d);
			cse_pkg::REG_Y_MIN:     ylo = $signed(d);
			cse_pkg::REG_Y_MAX:     yhi = $signed(d);
			cse_pkg::REG_GRID_COLS: ncols = d[10:0];
			cse_pkg::REG_GRID_ROWS: nrows = d[10:0];
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------- checker

	always @(posedge clk) begin
		seg_word_t w;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (pending_segs.size() == 0) begin
				$error("segment word with nothing expected");
				mismatches++;
			end else begin
				w = pending_segs.pop_front();
				if (out_if.start_x !== w.sx) begin
					$error("start_x expected %0d got %0d", w.sx, out_if.start_x);
					mismatches++;
				end
				if (out_if.start_y !== w.sy) begin
					$error("start_y expected %0d got %0d", w.sy, out_if.start_y);
					mismatches++;
				end
				if (out_if.end_x !== w.ex) begin
					$error("end_x expected %0d got %0d", w.ex, out_if.end_x);
					mismatches++;
				end
				if (out_if.end_y !== w.ey) begin
					$error("end_y expected %0d got %0d", w.ey, out_if.end_y);
					mismatches++;
				end
				if (out_if.triangle_index !== w.tri_idx) begin
					$error("triangle_index expected %0d got %0d", w.tri_idx,
						out_if.triangle_index);
					mismatches++;
				end
				if (out_if.last_of_cell !== w.last) begin
					$error("last_of_cell expected %0d got %0d", w.last,
						out_if.last_of_cell);
					mismatches++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	// Alternate bursts of ready with stalls; mostly short stalls, a few long ones.
	// A requested hold-off is counted down here and overrides everything.
	initial begin
		int left;
		bit phase;
		left = 0;
		phase = 1;
		out_if.ready <= 0;
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				out_if.ready <= 0;
				hold_off--;
			end else if (steady) begin
				out_if.ready <= 1;
			end else begin
				if (left == 0) begin
					phase = ($urandom_range(0, 9) < 7);
					if (phase)
						left = $urandom_range(1, 20);
					else if ($urandom_range(0, 9) < 8)
						left = $urandom_range(1, 3);
					else
						left = $urandom_range(6, 40);
				end
				left--;
				out_if.ready <= phase;
			end
		end
	end

	// ---------------------------------------------------------------- sender

	function automatic int idle_len();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one cell word, hold it until taken, then predict its segments.
	task automatic send_cell(cell_t c);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			in_if.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_if.valid           <= 1;
		in_if.cell_col        <= c.col;
		in_if.cell_row        <= c.row;
		in_if.value_low_left  <= c.z[0];
		in_if.value_low_right <= c.z[1];
		in_if.value_up_right  <= c.z[2];
		in_if.value_up_left   <= c.z[3];
		do @(posedge clk); while (!in_if.ready);
		trace_cell(c);
	endtask

	// Drop valid, drain the segments and let cells without segments clear the pipe.
	task automatic drain();
		in_if.valid <= 0;
		while (pending_segs.size() > 0)
			@(posedge clk);
		repeat (cse_pkg::PIPE_LAT + 20) @(posedge clk);
	endtask

	task automatic cfg_write(cse_pkg::reg_idx_t idx, logic [31:0] d);
		cfg_if.valid <= 1;
		cfg_if.addr  <= idx;
		cfg_if.data  <= d;
		do @(posedge clk); while (!cfg_if.ready);
		model_write(idx, d);
		cfg_if.valid <= 0;
		@(posedge clk);
	endtask

	task automatic set_area(logic [31:0] x0, logic [31:0] x1, logic [31:0] y0,
			logic [31:0] y1, logic [31:0] cols, logic [31:0] rows, logic [31:0] lv);
		drain();
		cfg_write(cse_pkg::REG_LEVEL, lv);
		cfg_write(cse_pkg::REG_X_MIN, x0);
		cfg_write(cse_pkg::REG_X_MAX, x1);
		cfg_write(cse_pkg::REG_Y_MIN, y0);
		cfg_write(cse_pkg::REG_Y_MAX, y1);
		cfg_write(cse_pkg::REG_GRID_COLS, cols);
		cfg_write(cse_pkg::REG_GRID_ROWS, rows);
	endtask

	function automatic cell_t mk_cell(int col, int row, int a, int b, int c, int d);
		cell_t x;
		x.col = 10'(col);
		x.row = 10'(row);
		x.z[0] = a;
		x.z[1] = b;
		x.z[2] = c;
		x.z[3] = d;
		return x;
	endfunction

	// Sample value: mostly close to the level so triangles get crossed,
	// sometimes exactly on it, sometimes anywhere in the 32-bit range.
	function automatic cse_pkg::q16_t rand_sample();
		longint v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: v = lvl + longint'($urandom_range(0, 8 * 65536)) - 4 * 65536;
			5:             v = lvl;
			6, 7:          v = $signed($urandom());
			8:             v = $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
			default:       v = lvl + ($urandom_range(0, 1) ? 1 : -1);
		endcase
		return v[31:0];
	endfunction

	function automatic cell_t rand_cell();
		cell_t c;
		if ($urandom_range(0, 3) == 0)
			c.col = 10'($urandom());
		else
			c.col = 10'($urandom_range(0, clamp_grid(ncols) - 2));
		if ($urandom_range(0, 3) == 0)
			c.row = 10'($urandom());
		else
			c.row = 10'($urandom_range(0, clamp_grid(nrows) - 2));
		for (int k = 0; k < 4; k++)
			c.z[k] = rand_sample();
		return c;
	endfunction

	// ---------------------------------------------------------------- tests

	// Reset settings: sign patterns, on-level vertices, flat cells, value extremes.
	task automatic test_reset_settings();
		send_cell(mk_cell(0, 0, 65536, -65536, 65536, -65536));
		send_cell(mk_cell(0, 0, 65536, 65536, -65536, -65536));
		send_cell(mk_cell(0, 0, 0, 65536, 0, -65536));
		send_cell(mk_cell(0, 0, 0, 0, 65536, -65536));
		send_cell(mk_cell(0, 0, 0, 0, 0, 0));
		send_cell(mk_cell(0, 0, 5, 5, 5, 5));
		send_cell(mk_cell(1, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
		send_cell(mk_cell(0, 1, -1, -1, -1, 3));
		send_cell(mk_cell(0, 0, 1, -1, 0, 0));
	endtask

	// Extreme area and grid sizes outside the legal range, which clamp.
	task automatic test_extreme_settings();
		set_area(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 0);
		send_cell(mk_cell(0, 0, 65536, -65536, 65536, -65536));
		send_cell(mk_cell(1023, 1023, 32'h7FFF_FFFF, 32'h8000_0000, -3, 2));
		send_cell(mk_cell(1022, 0, 1, -2, 3, -4));
		set_area(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 2047, 1024,
			32'h7FFF_FFFF);
		send_cell(mk_cell(0, 1023, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0));
		send_cell(mk_cell(512, 3, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
		set_area(-100 * 65536, 100 * 65536, 0, 3 * 65536, 1024, 2047, 32'h8000_0000);
		send_cell(mk_cell(1023, 0, 32'h8000_0000, 1, 32'h8000_0000, 32'h8000_0001));
		send_cell(mk_cell(5, 5, 0, -1, 2, 32'h8000_0000));
	endtask

	// Random settings per phase, random cells inside each.
	task automatic test_random_cells(int phases, int per_phase);
		logic [31:0] x0, y0, lv;
		for (int p = 0; p < phases; p++) begin
			x0 = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1 << 20) - (1 << 19);
			y0 = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1 << 20) - (1 << 19);
			lv = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1 << 18);
			set_area(x0, $urandom_range(0, 1) ? $urandom() : x0 + $urandom_range(1, 1 << 24),
				y0, $urandom_range(0, 1) ? $urandom() : y0 + $urandom_range(1, 1 << 24),
				$urandom_range(0, 4) == 0 ? $urandom() : $urandom_range(2, 64),
				$urandom_range(0, 4) == 0 ? $urandom() : $urandom_range(2, 64), lv);
			// every third phase runs without idling at all
			steady = p % 3 == 2;
			for (int k = 0; k < per_phase; k++)
				send_cell(rand_cell());
			steady = 0;
		end
	endtask

	// Hold the receiver off for a long stretch while cells keep coming.
	task automatic test_output_stall();
		drain();
		steady = 1;
		hold_off = 400;
		for (int k = 0; k < 40; k++)
			send_cell(mk_cell(k, k, 65536 + k, -65536, 65536, -65536 - k));
		steady = 0;
	endtask

	initial begin
		arst_n = 0;
		cfg_if.valid <= 0;
		cfg_if.addr  <= cse_pkg::REG_LEVEL;
		cfg_if.data  <= 0;
		in_if.valid  <= 0;
		in_if.cell_col        <= 0;
		in_if.cell_row        <= 0;
		in_if.value_low_left  <= 0;
		in_if.value_low_right <= 0;
		in_if.value_up_right  <= 0;
		in_if.value_up_left   <= 0;
		lvl = 0; xlo = 0; xhi = 65536; ylo = 0; yhi = 65536;
		ncols = 2; nrows = 2;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		test_reset_settings();
		test_extreme_settings();
		test_random_cells(8, 30);
		test_output_stall();

		drain();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
